>>> rtl/adlf_pkg.sv
// types, constants and helpers shared by the duplicate line filter
`timescale 1ns / 1ps
package adlf_pkg;

   localparam logic [7:0] NEWLINE = 8'd10;
   localparam logic [31:0] COUNT_SAT = 32'hFFFF_FFFE;

   localparam logic [2:0] CSR_COUNT_MODE    = 3'd0;
   localparam logic [2:0] CSR_SHOW_REPEATED = 3'd1;
   localparam logic [2:0] CSR_SHOW_SINGLE   = 3'd2;
   localparam logic [2:0] CSR_SKIP_FIELDS   = 3'd3;
   localparam logic [2:0] CSR_SKIP_CHARS    = 3'd4;

   typedef struct packed {
      logic        count_mode;
      logic        show_repeated;
      logic        show_single;
      logic [12:0] skip_fields;
      logic [12:0] skip_chars;
   } cfg_type;

   typedef struct packed {
      logic        line_bank;
      logic [12:0] line_length;
      logic [31:0] group_count;
      logic        print_plain;
      logic        print_counted;
      logic        last_of_run;
   } rsp_type;

   function automatic logic is_blank(logic [7:0] b);
      return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
   endfunction

   function automatic rsp_type make_rsp(logic bank, logic [12:0] len, logic [31:0] rc,
                                        cfg_type cfg);
      rsp_type r;
      r.line_bank     = bank;
      r.line_length   = len;
      r.group_count   = rc + 32'd1;
      r.print_plain   = (cfg.show_repeated && (rc != 32'd0)) ||
                        (cfg.show_single && (rc == 32'd0));
      r.print_counted = cfg.count_mode;
      r.last_of_run   = 1'b0;
      return r;
   endfunction

endpackage

>>> rtl/adlf_front.sv
// front end: line splitting, key skipping, key compare against the group line, grouping
`timescale 1ns / 1ps
module adlf_front #(
   parameter int LINE_BYTES = 8192
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic              in_stall,
   input  logic              in_kind,
   input  logic [7:0]        in_byte,
   input  adlf_pkg::cfg_type cfg,
   output logic [1:0]        out_cnt,
   output adlf_pkg::rsp_type out_res0,
   output adlf_pkg::rsp_type out_res1
);
   localparam int LW = $clog2(LINE_BYTES);
   localparam int AW = LW + 1;
   localparam logic [LW-1:0] LAST_LEN = LW'(LINE_BYTES - 1);

   logic [7:0] line_store [2**AW];

   logic          gbank_ff, gbank_in, gvalid_ff, gvalid_in;
   logic [LW-1:0] gll_ff, gll_in, gks_ff, gks_in, len_ff, len_in, cks_ff, cks_in;
   logic [12:0]   fl_ff, fl_in, cl_ff, cl_in;
   logic          inf_ff, inf_in, km_ff, km_in;
   logic [31:0]   rc_ff, rc_in;
   logic [7:0]    rd_q_ff, byp_data_ff;
   logic          byp_ff, byp_in;

   logic          accept, wbank, wr_en, do_close, end_rpt, joins, a_v, b_v;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    rd_data;
   logic [LW-1:0] cmp_i, glen;
   adlf_pkg::rsp_type res_a, res_b;

   always_comb begin
      gbank_in = gbank_ff;
      gvalid_in = gvalid_ff;
      gll_in = gll_ff;
      gks_in = gks_ff;
      len_in = len_ff;
      cks_in = cks_ff;
      fl_in = fl_ff;
      cl_in = cl_ff;
      inf_in = inf_ff;
      km_in = km_ff;
      rc_in = rc_ff;
      wr_en = 1'b0;
      do_close = 1'b0;
      end_rpt = 1'b0;
      joins = 1'b0;
      a_v = 1'b0;
      b_v = 1'b0;
      res_a = '0;
      res_b = '0;
      cmp_i = len_ff - cks_ff;
      glen = gll_ff - gks_ff;
      accept = in_valid && !in_stall;
      rd_data = byp_ff ? byp_data_ff : rd_q_ff;
      wbank = gvalid_ff ? ~gbank_ff : gbank_ff;
      wr_addr = {wbank, len_ff};
      if (accept) begin
         if (!in_kind) begin
            if (len_ff == '0) begin
               fl_in = cfg.skip_fields;
               cl_in = cfg.skip_chars;
               inf_in = 1'b0;
               km_in = 1'b0;
               cks_in = '0;
            end
            wr_en = 1'b1;
            if (fl_in != 13'd0) begin
               if (adlf_pkg::is_blank(in_byte)) begin
                  if (inf_in) begin
                     inf_in = 1'b0;
                     fl_in = fl_in - 13'd1;
                  end
               end else begin
                  inf_in = 1'b1;
               end
               cks_in = cks_in + 1'b1;
            end else if (cl_in != 13'd0) begin
               cl_in = cl_in - 13'd1;
               cks_in = cks_in + 1'b1;
            end else if (gvalid_ff && !km_in) begin
               cmp_i = len_ff - cks_in;
               if ((cmp_i >= glen) || (rd_data != in_byte)) begin
                  km_in = 1'b1;
               end
            end
            len_in = len_ff + 1'b1;
            do_close = (in_byte == adlf_pkg::NEWLINE) || (len_in == LAST_LEN);
         end else begin
            do_close = (len_ff != '0);
            end_rpt = 1'b1;
         end
      end
      if (do_close) begin
         if (gvalid_ff) begin
            if (glen != (len_in - cks_in)) begin
               km_in = 1'b1;
            end
            if (!km_in) begin
               joins = 1'b1;
               if (rc_ff < adlf_pkg::COUNT_SAT) begin
                  rc_in = rc_ff + 32'd1;
               end
            end else begin
               a_v = 1'b1;
               res_a = adlf_pkg::make_rsp(gbank_ff, 13'(gll_ff), rc_ff, cfg);
            end
         end
         if (!joins) begin
            gbank_in = wbank;
            gvalid_in = 1'b1;
            gll_in = len_in;
            gks_in = cks_in;
            rc_in = '0;
         end
         len_in = '0;
         cks_in = '0;
         km_in = 1'b0;
         inf_in = 1'b0;
      end
      if (end_rpt && gvalid_in) begin
         b_v = 1'b1;
         res_b = adlf_pkg::make_rsp(gbank_in, 13'(gll_in), rc_in, cfg);
         gvalid_in = 1'b0;
         rc_in = '0;
      end
      // pack results, mark the final one
      out_res0 = a_v ? res_a : res_b;
      out_res1 = res_b;
      out_cnt = {1'b0, a_v} + {1'b0, b_v};
      if (out_cnt == 2'd2) begin
         out_res1.last_of_run = 1'b1;
      end else if (out_cnt == 2'd1) begin
         out_res0.last_of_run = 1'b1;
      end
      // prefetch the group byte the next compare needs
      rd_addr = {gbank_in, gks_in + len_in - cks_in};
      byp_in = wr_en && (wr_addr == rd_addr);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_store[wr_addr] <= in_byte;
      end
      rd_q_ff <= line_store[rd_addr];
      byp_data_ff <= in_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gbank_ff <= 1'b0;
         gvalid_ff <= 1'b0;
         gll_ff <= '0;
         gks_ff <= '0;
         len_ff <= '0;
         cks_ff <= '0;
         fl_ff <= '0;
         cl_ff <= '0;
         inf_ff <= 1'b0;
         km_ff <= 1'b0;
         rc_ff <= '0;
         byp_ff <= 1'b0;
      end else begin
         gbank_ff <= gbank_in;
         gvalid_ff <= gvalid_in;
         gll_ff <= gll_in;
         gks_ff <= gks_in;
         len_ff <= len_in;
         cks_ff <= cks_in;
         fl_ff <= fl_in;
         cl_ff <= cl_in;
         inf_ff <= inf_in;
         km_ff <= km_in;
         rc_ff <= rc_in;
         byp_ff <= byp_in;
      end
   end

endmodule

>>> rtl/adlf_queue.sv
// back end: four entry result queue taking up to two results a cycle
`timescale 1ns / 1ps
module adlf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        push_cnt,
   input  adlf_pkg::rsp_type push0,
   input  adlf_pkg::rsp_type push1,
   output logic              full,
   output logic              out_valid,
   input  logic              out_stall,
   output adlf_pkg::rsp_type out_data
);
   adlf_pkg::rsp_type q_ff [4];
   logic [1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       pop;

   always_comb begin
      pop = out_valid && !out_stall;
      wp_in = wp_ff + push_cnt;
      rp_in = rp_ff + {1'b0, pop};
      cnt_in = cnt_ff + {1'b0, push_cnt} - {2'b0, pop};
      full = cnt_ff > 3'd2;
      out_valid = cnt_ff != 3'd0;
      out_data = q_ff[rp_ff];
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         q_ff[wp_ff] <= push0;
      end
      if (push_cnt == 2'd2) begin
         q_ff[wp_ff + 2'd1] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

>>> rtl/adjacent_duplicate_line_filter_top.sv
// top level of the adjacent duplicate line filter
// a request that closes a group writes its result into the result queue, shown from its head
// one request per cycle bar stalls, set by the single line buffer write and prefetched read
// a request may give up to two results; the result queue stalls requests when nearly full
// reset: synchronous, clears grouping state, queue and registers to their defaults
// the line buffer is not cleared; no clearing pass, requests are taken right after reset
`timescale 1ns / 1ps
module adjacent_duplicate_line_filter_top #(
   parameter int LINE_BYTES = 8192
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_text_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_line_bank,
   output logic [12:0] rsp_line_length,
   output logic [31:0] rsp_group_count,
   output logic        rsp_print_plain,
   output logic        rsp_print_counted,
   output logic        rsp_last_of_run,
   // register write port
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [12:0] csr_write_data
);
   adlf_pkg::cfg_type cfg_ff, cfg_in;
   adlf_pkg::rsp_type res0, res1, head;
   logic [1:0]        res_cnt;
   logic              q_full;

   // register writes, indexes beyond the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            adlf_pkg::CSR_COUNT_MODE:    cfg_in.count_mode = csr_write_data[0];
            adlf_pkg::CSR_SHOW_REPEATED: cfg_in.show_repeated = csr_write_data[0];
            adlf_pkg::CSR_SHOW_SINGLE:   cfg_in.show_single = csr_write_data[0];
            adlf_pkg::CSR_SKIP_FIELDS:   cfg_in.skip_fields = csr_write_data;
            adlf_pkg::CSR_SKIP_CHARS:    cfg_in.skip_chars = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.count_mode <= 1'b0;
         cfg_ff.show_repeated <= 1'b1;
         cfg_ff.show_single <= 1'b1;
         cfg_ff.skip_fields <= '0;
         cfg_ff.skip_chars <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // stall requests while the queue cannot take two more results
   assign req_stall = q_full;

   adlf_front #(
      .LINE_BYTES(LINE_BYTES)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .in_valid(req_valid),
      .in_stall(q_full),
      .in_kind(req_kind),
      .in_byte(req_text_byte),
      .cfg(cfg_ff),
      .out_cnt(res_cnt),
      .out_res0(res0),
      .out_res1(res1)
   );

   adlf_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_cnt(res_cnt),
      .push0(res0),
      .push1(res1),
      .full(q_full),
      .out_valid(rsp_valid),
      .out_stall(rsp_stall),
      .out_data(head)
   );

   // result fields straight from the queue head
   assign rsp_line_bank = head.line_bank;
   assign rsp_line_length = head.line_length;
   assign rsp_group_count = head.group_count;
   assign rsp_print_plain = head.print_plain;
   assign rsp_print_counted = head.print_counted;
   assign rsp_last_of_run = head.last_of_run;

endmodule
